@@ src/point_in_polygon_test_core_defines.svh @@
// Assertion macros for the point-in-polygon core and its port checker.
// Included by the checker file; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pip_pkg.sv @@
// Shared types and constants for the point-in-polygon core.
// No dependencies; imported by the crossing pipeline, the top level and the checker.
`timescale 1ns / 1ps

package pip_pkg;

  // Default sizing
  localparam int DEF_MAX_POLYGONS = 64;
  localparam int DEF_MAX_EDGES    = 64;
  localparam int DEF_COORD_BITS   = 16;

  // Fixed field widths of the transactions
  localparam int ID_BITS    = 6;
  localparam int FIELD_BITS = 16;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic [ID_BITS-1:0]           polygon_id;
    logic [ID_BITS-1:0]           edge_index;
    logic                         last_edge;
    logic signed [FIELD_BITS-1:0] start_x;
    logic signed [FIELD_BITS-1:0] start_y;
    logic signed [FIELD_BITS-1:0] end_x;
    logic signed [FIELD_BITS-1:0] end_y;
    logic signed [FIELD_BITS-1:0] query_x;
    logic signed [FIELD_BITS-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [ID_BITS-1:0] queried_polygon;
  } out_item_t;

  // Status of the crossing pipeline, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic parity;
  } cross_stat_t;

endpackage

@@ src/pip_edge_mem.sv @@
// Edge store: one write port, one registered read port.
// Uses no package items.
`timescale 1ns / 1ps

module pip_edge_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  output logic          rd_valid
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic          rd_valid_r;

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Read data valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

@@ src/pip_cross_pipe.sv @@
// Crossing-test pipeline: span check, cross-multiply, compare, parity toggle.
// Depends on pip_pkg for the status struct.
`timescale 1ns / 1ps

module pip_cross_pipe #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  edge_vld,
  input  logic [4*CW-1:0]       edge_data,
  input  logic signed [CW-1:0]  qx,
  input  logic signed [CW-1:0]  qy,
  output pip_pkg::cross_stat_t  stat
);

  import pip_pkg::*;

  localparam int DW1 = CW + 1;
  localparam int PW  = 2 * DW1;

  logic signed [CW-1:0] ax, ay, bx, by;
  logic                 span, dpos;

  // Stage 1: differences
  logic                  s1_vld_r, s1_span_r, s1_dpos_r;
  logic signed [DW1-1:0] s1_dxq_r, s1_d_r, s1_ex_r, s1_ey_r;

  // Stage 2: products
  logic                 s2_vld_r, s2_span_r, s2_dpos_r;
  logic signed [PW-1:0] s2_lhs_r, s2_rhs_r;

  logic parity_r;
  logic hit;

  assign ax = edge_data[4*CW-1:3*CW];
  assign ay = edge_data[3*CW-1:2*CW];
  assign bx = edge_data[2*CW-1:CW];
  assign by = edge_data[CW-1:0];

  // Half-open y span; d > 0 exactly when ay < by
  assign span = ((ay <= qy) && (qy < by)) || ((by <= qy) && (qy < ay));
  assign dpos = (ay < by);

  always_ff @(posedge clk) begin
    s1_span_r <= span;
    s1_dpos_r <= dpos;
    s1_dxq_r  <= DW1'(qx) - DW1'(ax);
    s1_d_r    <= DW1'(by) - DW1'(ay);
    s1_ex_r   <= DW1'(bx) - DW1'(ax);
    s1_ey_r   <= DW1'(qy) - DW1'(ay);
    s2_span_r <= s1_span_r;
    s2_dpos_r <= s1_dpos_r;
    s2_lhs_r  <= PW'(s1_dxq_r) * PW'(s1_d_r);
    s2_rhs_r  <= PW'(s1_ex_r) * PW'(s1_ey_r);
  end

  // Compare with the sign of d folded in
  assign hit = s2_vld_r && s2_span_r &&
               (s2_dpos_r ? (s2_lhs_r < s2_rhs_r) : (s2_lhs_r > s2_rhs_r));

  // Stage valids and parity accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      s1_vld_r <= edge_vld;
      s2_vld_r <= s1_vld_r;
      if (clear) begin
        parity_r <= 1'b0;
      end else if (hit) begin
        parity_r <= ~parity_r;
      end
    end
  end

  assign stat.busy   = s1_vld_r | s2_vld_r;
  assign stat.parity = parity_r;

endmodule

@@ src/point_in_polygon_test_core.sv @@
// Top level of the point-in-polygon core: sequencer, edge counts, store, pipeline.
// Depends on pip_pkg, pip_edge_mem and pip_cross_pipe.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | edge load or point query
//  output  | out_valid, out_ready, out_data | inside flag and polygon id
//
// A load is done at the accepting edge, where it writes the edge store.
// A query reads its edge count, then one stored edge per cycle; the sequencer then
// drains the crossing pipeline and loads the result, skipping the walk if empty.
// One transaction is worked at a time; a finished result sits in the output
// register, and loads keep flowing while it waits; a query finishing then waits.
// Reset clears the edge-count valid flags and control state, not the memories.
`timescale 1ns / 1ps

module point_in_polygon_test_core #(
  parameter int MAX_POLYGONS = pip_pkg::DEF_MAX_POLYGONS,
  parameter int MAX_EDGES    = pip_pkg::DEF_MAX_EDGES,
  parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pip_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pip_pkg::out_item_t out_data
);

  import pip_pkg::*;

  // Effective sizes: ids and indexes are six bits wide
  localparam int NP    = (MAX_POLYGONS < 64) ? MAX_POLYGONS : 64;
  localparam int NE    = (MAX_EDGES < 64) ? MAX_EDGES : 64;
  localparam int CW    = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int PIDW  = (NP > 1) ? $clog2(NP) : 1;
  localparam int EW    = $clog2(NE);
  localparam int CNTW  = $clog2(NE + 1);
  localparam int DEPTH = NP * NE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t               state_r;
  logic [PIDW-1:0]      pid_r;
  logic [ID_BITS-1:0]   qid_r;
  logic [CNTW-1:0]      n_r;
  logic [EW-1:0]        walk_r;
  logic signed [CW-1:0] qx_r, qy_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // Edge count memory, its valid flags and its read register
  logic [CNTW-1:0]      counts_mem [NP];
  logic [NP-1:0]        cnt_vld_r;
  logic [CNTW-1:0]      cnt_q_r;
  logic                 cnt_ok_r;

  logic                 accept, is_load, is_query;
  logic                 pid_ok, eidx_ok;
  logic [PIDW-1:0]      pid_idx;
  logic [EW-1:0]        eidx_idx;
  logic [CNTW-1:0]      cnt_eff;
  logic                 cnt_wr, out_load;
  logic                 wr_en, rd_en, rd_valid, last_issue;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [4*CW-1:0]      wr_data, rd_data;
  cross_stat_t          xstat;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (in_data.operation == OP_LOAD);
  assign is_query = accept && (in_data.operation == OP_QUERY);

  // Range checks and indexes
  assign pid_ok   = 32'(in_data.polygon_id) < NP;
  assign eidx_ok  = 32'(in_data.edge_index) < NE;
  assign pid_idx  = in_data.polygon_id[PIDW-1:0];
  assign eidx_idx = in_data.edge_index[EW-1:0];

  // Edge store write on a load transaction
  assign wr_en   = is_load && pid_ok && eidx_ok;
  assign wr_addr = AW'(32'(pid_idx) * NE + 32'(eidx_idx));
  assign wr_data = {in_data.start_x[CW-1:0], in_data.start_y[CW-1:0],
                    in_data.end_x[CW-1:0], in_data.end_y[CW-1:0]};

  // Edge walk reads
  assign rd_en      = (state_r == S_WALK);
  assign rd_addr    = AW'(32'(pid_r) * NE + 32'(walk_r));
  assign last_issue = (CNTW'(walk_r) + CNTW'(1)) == n_r;

  // Count update on a last edge; count of a never-written polygon is zero
  assign cnt_wr  = wr_en && in_data.last_edge;
  assign cnt_eff = cnt_ok_r ? cnt_q_r : '0;

  // Result register loads once the previous result is gone or leaving
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Edge count memory with registered read
  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      counts_mem[pid_idx] <= CNTW'(32'(in_data.edge_index) + 1);
    end
    if (is_query) begin
      cnt_q_r <= counts_mem[pid_idx];
    end
  end

  // Count valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      cnt_ok_r  <= 1'b0;
    end else begin
      if (cnt_wr) begin
        cnt_vld_r[pid_idx] <= 1'b1;
      end
      if (is_query) begin
        cnt_ok_r <= pid_ok && cnt_vld_r[pid_idx];
      end
    end
  end

  // Query operands
  always_ff @(posedge clk) begin
    if (is_query) begin
      pid_r <= pid_idx;
      qid_r <= in_data.polygon_id;
      qx_r  <= in_data.query_x[CW-1:0];
      qy_r  <= in_data.query_y[CW-1:0];
    end
  end

  // Sequencer with the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          walk_r <= '0;
          if (is_query) begin
            state_r <= S_COUNT;
          end
        end
        S_COUNT: begin
          n_r     <= cnt_eff;
          state_r <= (cnt_eff == '0) ? S_DRAIN : S_WALK;
        end
        S_WALK: begin
          walk_r <= walk_r + EW'(1);
          if (last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !xstat.busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r.inside_res      <= xstat.parity;
            out_data_r.queried_polygon <= qid_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pip_edge_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (4 * CW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  pip_cross_pipe #(
    .CW (CW)
  ) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (is_query),
    .edge_vld  (rd_valid),
    .edge_data (rd_data),
    .qx        (qx_r),
    .qy        (qy_r),
    .stat      (xstat)
  );

endmodule

@@ src/pip_checker.sv @@
// Port-level checker for the point-in-polygon core, bound to the top level.
// Depends on pip_pkg and point_in_polygon_test_core_defines.svh.
`timescale 1ns / 1ps
`include "point_in_polygon_test_core_defines.svh"

module pip_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pip_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pip_pkg::out_item_t out_data
);

  import pip_pkg::*;

  // A pending result holds its value until taken
  `PIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A query transaction closes the input once accepted
  `PIP_ASSERT_NEXT(a_query_blocks, clk, rst_n, in_valid && in_ready && in_data.operation == OP_QUERY, !in_ready, "input open during query walk")

  // A load transaction leaves the input open
  `PIP_ASSERT_NEXT(a_load_open, clk, rst_n, in_valid && in_ready && in_data.operation == OP_LOAD, in_ready, "input closed after load")

  // A fresh result arrives with the sequencer idle again
  `PIP_ASSERT_NOW(a_result_idle, clk, rst_n, $rose(out_valid), in_ready, "result issued while busy")

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
